// ===== rtl/ptom_pkg.sv =====
// Shared types and codes for the price-time order matcher.
`default_nettype none
package ptom_pkg;
  localparam logic [1:0] KIND_FILL = 2'd0;
  localparam logic [1:0] KIND_RESTED = 2'd1;
  localparam logic [1:0] KIND_FILLED = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;
  localparam int unsigned COUNT_BITS = 7;

  // Command broadcast from the controller to every cell of one side.
  typedef struct packed {
    logic pop;     // drop the head entry, shift every entry one place forward
    logic dec;     // subtract from the head quantity
    logic ins;     // insert the broadcast order in sorted position
  } cell_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/ptom_cell.sv =====
// One cell of a sorted side chain: holds one resting order.
`default_nettype none
module ptom_cell #(
  parameter int unsigned PRICE_BITS = 24,
  parameter int unsigned QTY_BITS = 32,
  parameter int unsigned ID_BITS = 32,
  parameter bit IS_BID = 1'b1
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  ptom_pkg::cell_cmd_t   cmd_i,
  input  wire  [QTY_BITS-1:0]   dec_qty_i,
  input  wire  [PRICE_BITS-1:0] new_price_i,
  input  wire  [QTY_BITS-1:0]   new_qty_i,
  input  wire  [ID_BITS-1:0]    new_id_i,
  // previous (better) neighbor
  input  wire                   prev_valid_i,
  input  wire                   prev_after_i,
  input  wire  [PRICE_BITS-1:0] prev_price_i,
  input  wire  [QTY_BITS-1:0]   prev_qty_i,
  input  wire  [ID_BITS-1:0]    prev_id_i,
  // next (worse) neighbor
  input  wire                   next_valid_i,
  input  wire  [PRICE_BITS-1:0] next_price_i,
  input  wire  [QTY_BITS-1:0]   next_qty_i,
  input  wire  [ID_BITS-1:0]    next_id_i,
  input  wire                   is_head_i,
  output logic                  valid_o,
  output logic                  after_o,
  output logic [PRICE_BITS-1:0] price_o,
  output logic [QTY_BITS-1:0]   qty_o,
  output logic [ID_BITS-1:0]    id_o
);
  logic                  valid_q, valid_d;
  logic [PRICE_BITS-1:0] price_q, price_d;
  logic [QTY_BITS-1:0]   qty_q, qty_d;
  logic [ID_BITS-1:0]    id_q, id_d;
  logic                  keeps;

  // New order goes behind this entry when this entry is at least as good.
  assign keeps = valid_q && (IS_BID ? (price_q >= new_price_i) : (price_q <= new_price_i));
  assign after_o = keeps;

  always_comb begin
    valid_d = valid_q;
    price_d = price_q;
    qty_d = qty_q;
    id_d = id_q;
    if (cmd_i.pop) begin
      valid_d = next_valid_i;
      price_d = next_price_i;
      qty_d = next_qty_i;
      id_d = next_id_i;
    end else if (cmd_i.dec) begin
      if (is_head_i) begin
        qty_d = qty_q - dec_qty_i;
      end
    end else if (cmd_i.ins) begin
      if (!keeps) begin
        if (prev_after_i) begin
          valid_d = 1'b1;
          price_d = new_price_i;
          qty_d = new_qty_i;
          id_d = new_id_i;
        end else begin
          valid_d = prev_valid_i;
          price_d = prev_price_i;
          qty_d = prev_qty_i;
          id_d = prev_id_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    qty_q <= qty_d;
    id_q <= id_d;
  end

  assign valid_o = valid_q;
  assign price_o = price_q;
  assign qty_o = qty_q;
  assign id_o = id_q;
endmodule
`default_nettype wire

// ===== rtl/ptom_chain.sv =====
// A sorted chain of cells holding one side of the book, best entry first.
`default_nettype none
module ptom_chain #(
  parameter int unsigned SIDE_DEPTH = 32,
  parameter int unsigned PRICE_BITS = 24,
  parameter int unsigned QTY_BITS = 32,
  parameter int unsigned ID_BITS = 32,
  parameter bit IS_BID = 1'b1
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  ptom_pkg::cell_cmd_t   cmd_i,
  input  wire  [QTY_BITS-1:0]   dec_qty_i,
  input  wire  [PRICE_BITS-1:0] new_price_i,
  input  wire  [QTY_BITS-1:0]   new_qty_i,
  input  wire  [ID_BITS-1:0]    new_id_i,
  output logic                  head_valid_o,
  output logic [PRICE_BITS-1:0] head_price_o,
  output logic [QTY_BITS-1:0]   head_qty_o,
  output logic [ID_BITS-1:0]    head_id_o,
  output logic                  full_o,
  output logic [$clog2(SIDE_DEPTH+1)-1:0] count_o
);
  localparam int unsigned CW = $clog2(SIDE_DEPTH+1);
  logic [SIDE_DEPTH:0]   valid_w, after_w;
  logic [PRICE_BITS-1:0] price_w [SIDE_DEPTH+1];
  logic [QTY_BITS-1:0]   qty_w [SIDE_DEPTH+1];
  logic [ID_BITS-1:0]    id_w [SIDE_DEPTH+1];
  logic [CW-1:0]         count_q;

  // Slot SIDE_DEPTH is an empty sentinel past the tail.
  assign valid_w[SIDE_DEPTH] = 1'b0;
  assign after_w[SIDE_DEPTH] = 1'b0;
  assign price_w[SIDE_DEPTH] = '0;
  assign qty_w[SIDE_DEPTH] = '0;
  assign id_w[SIDE_DEPTH] = '0;

  for (genvar g = 0; g < SIDE_DEPTH; g++) begin : g_cell
    logic                  pv, pa;
    logic [PRICE_BITS-1:0] pp;
    logic [QTY_BITS-1:0]   pq;
    logic [ID_BITS-1:0]    pi;
    if (g == 0) begin : g_head
      assign pv = 1'b0;
      assign pa = 1'b1;
      assign pp = '0;
      assign pq = '0;
      assign pi = '0;
    end else begin : g_body
      assign pv = valid_w[g-1];
      assign pa = after_w[g-1];
      assign pp = price_w[g-1];
      assign pq = qty_w[g-1];
      assign pi = id_w[g-1];
    end
    ptom_cell #(
      .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS), .ID_BITS(ID_BITS), .IS_BID(IS_BID)
    ) u_cell (
      .clk_i, .rst_ni, .cmd_i, .dec_qty_i, .new_price_i, .new_qty_i, .new_id_i,
      .prev_valid_i(pv), .prev_after_i(pa), .prev_price_i(pp), .prev_qty_i(pq),
      .prev_id_i(pi),
      .next_valid_i(valid_w[g+1]), .next_price_i(price_w[g+1]),
      .next_qty_i(qty_w[g+1]), .next_id_i(id_w[g+1]),
      .is_head_i(g == 0),
      .valid_o(valid_w[g]), .after_o(after_w[g]), .price_o(price_w[g]),
      .qty_o(qty_w[g]), .id_o(id_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.pop) begin
      count_q <= count_q - CW'(1);
    end else if (cmd_i.ins) begin
      count_q <= count_q + CW'(1);
    end
  end

  assign head_valid_o = valid_w[0];
  assign head_price_o = price_w[0];
  assign head_qty_o = qty_w[0];
  assign head_id_o = id_w[0];
  assign full_o = valid_w[SIDE_DEPTH-1];
  assign count_o = count_q;
endmodule
`default_nettype wire

// ===== rtl/price_time_order_matcher_top.sv =====
// Top level of the price-time priority limit order matcher.
// Usage:
//   Orders enter on the s_axis channel, one word per order. Results leave on
//   m_axis: one fill word per trade against a resting order, then one final
//   word with tlast high that reports rested, fully filled or rejected.
//   Each side of the book is a chain of SIDE_DEPTH cells kept sorted, best
//   first; fills take the head cell, inserts shift the tail. An order is
//   accepted, then its fill words go out one after another, then the final
//   word. The head compare and quantity subtract in the controller set the
//   one-fill-per-cycle pace while the output register is not stalled.
//   Only one order is in work at a time; s_axis_tready is low while it matches.
//   Reset empties both sides at once (valid bits clear); no sweep is needed.
//   When m_axis_tready is low the pending word holds in the output register
//   and the book holds still until it is taken; the next order may be
//   accepted meanwhile but waits before touching the book.
`default_nettype none
module price_time_order_matcher_top #(
  parameter int unsigned SIDE_DEPTH = 32,
  parameter int unsigned PRICE_BITS = 24,
  parameter int unsigned QTY_BITS = 32,
  parameter int unsigned ID_BITS = 32
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  s_axis_tvalid,
  output logic s_axis_tready,
  // tdata, low bit up: order_id, price, quantity (zero padded)
  input  wire  [((ID_BITS+PRICE_BITS+QTY_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: side
  input  wire  s_axis_tuser,
  output logic m_axis_tvalid,
  input  wire  m_axis_tready,
  // tdata, low bit up: incoming_id, resting_id, traded_qty, trade_price,
  // incoming_left, resting_left, best_bid, best_ask, resting_count (zero padded)
  output logic [((2*ID_BITS+3*QTY_BITS+3*PRICE_BITS+2+7+7)/8)*8-1:0] m_axis_tdata,
  // tuser: kind
  output logic [1:0] m_axis_tuser,
  output logic m_axis_tlast
);
  localparam int unsigned OB = 2*ID_BITS+3*QTY_BITS+3*PRICE_BITS+2+7;
  localparam int unsigned OW = ((OB+7)/8)*8;
  localparam int unsigned CW = $clog2(SIDE_DEPTH+1);
  localparam int unsigned RC = ptom_pkg::COUNT_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_MATCH} state_e;

  state_e                state_q;
  logic                  sell_q;
  logic [ID_BITS-1:0]    oid_q;
  logic [PRICE_BITS-1:0] px_q;
  logic [QTY_BITS-1:0]   q_q;
  logic [CW-1:0]         k_q;
  logic                  ovalid_q, olast_q;
  logic [1:0]            okind_q;
  logic [ID_BITS-1:0]    oinc_id_q;
  logic [ID_BITS-1:0]    ores_id_q;
  logic [QTY_BITS-1:0]   otraded_q, oleft_q, orleft_q;
  logic [PRICE_BITS-1:0] oprice_q;

  ptom_pkg::cell_cmd_t   bid_cmd, ask_cmd;
  logic [QTY_BITS-1:0]   t_qty;
  logic                  bh_v, ah_v, b_full, a_full;
  logic [PRICE_BITS-1:0] bh_p, ah_p;
  logic [QTY_BITS-1:0]   bh_q, ah_q;
  logic [ID_BITS-1:0]    bh_i, ah_i;
  logic [CW-1:0]         b_cnt, a_cnt;

  logic                  oh_v;
  logic [PRICE_BITS-1:0] oh_p;
  logic [QTY_BITS-1:0]   oh_q;
  logic [ID_BITS-1:0]    oh_i;
  logic                  crosses, do_fill, out_free, own_full;

  assign oh_v = sell_q ? bh_v : ah_v;
  assign oh_p = sell_q ? bh_p : ah_p;
  assign oh_q = sell_q ? bh_q : ah_q;
  assign oh_i = sell_q ? bh_i : ah_i;
  assign crosses = sell_q ? (oh_p >= px_q) : (oh_p <= px_q);
  assign t_qty = (q_q < oh_q) ? q_q : oh_q;
  assign out_free = !ovalid_q || m_axis_tready;
  assign own_full = sell_q ? a_full : b_full;
  assign do_fill = (state_q == ST_MATCH) && out_free && (q_q != '0) && oh_v && crosses
                   && (k_q < CW'(SIDE_DEPTH));

  always_comb begin
    bid_cmd = '0;
    ask_cmd = '0;
    if (do_fill) begin
      if (sell_q) begin
        bid_cmd.pop = (oh_q == t_qty);
        bid_cmd.dec = (oh_q != t_qty);
      end else begin
        ask_cmd.pop = (oh_q == t_qty);
        ask_cmd.dec = (oh_q != t_qty);
      end
    end else if ((state_q == ST_MATCH) && out_free && (q_q != '0) && !own_full) begin
      ask_cmd.ins = sell_q;
      bid_cmd.ins = !sell_q;
    end
  end

  ptom_chain #(.SIDE_DEPTH(SIDE_DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS),
    .ID_BITS(ID_BITS), .IS_BID(1'b1)) u_bids (
    .clk_i, .rst_ni, .cmd_i(bid_cmd), .dec_qty_i(t_qty), .new_price_i(px_q),
    .new_qty_i(q_q), .new_id_i(oid_q), .head_valid_o(bh_v), .head_price_o(bh_p),
    .head_qty_o(bh_q), .head_id_o(bh_i), .full_o(b_full), .count_o(b_cnt)
  );

  ptom_chain #(.SIDE_DEPTH(SIDE_DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS),
    .ID_BITS(ID_BITS), .IS_BID(1'b0)) u_asks (
    .clk_i, .rst_ni, .cmd_i(ask_cmd), .dec_qty_i(t_qty), .new_price_i(px_q),
    .new_qty_i(q_q), .new_id_i(oid_q), .head_valid_o(ah_v), .head_price_o(ah_p),
    .head_qty_o(ah_q), .head_id_o(ah_i), .full_o(a_full), .count_o(a_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovalid_q <= 1'b0;
      olast_q <= 1'b0;
      okind_q <= ptom_pkg::KIND_FILL;
    end else begin
      if ((state_q == ST_MATCH) && out_free) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            sell_q <= s_axis_tuser;
            oid_q <= s_axis_tdata[ID_BITS-1:0];
            px_q <= s_axis_tdata[ID_BITS +: PRICE_BITS];
            q_q <= s_axis_tdata[ID_BITS+PRICE_BITS +: QTY_BITS];
            k_q <= '0;
            state_q <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          if (out_free) begin
            oinc_id_q <= oid_q;
            if (do_fill) begin
              q_q <= q_q - t_qty;
              k_q <= k_q + CW'(1);
              okind_q <= ptom_pkg::KIND_FILL;
              olast_q <= 1'b0;
              ores_id_q <= oh_i;
              otraded_q <= t_qty;
              oprice_q <= oh_p;
              oleft_q <= q_q - t_qty;
              orleft_q <= oh_q - t_qty;
            end else begin
              olast_q <= 1'b1;
              ores_id_q <= '0;
              otraded_q <= '0;
              oprice_q <= '0;
              oleft_q <= q_q;
              orleft_q <= '0;
              if (q_q == '0) begin
                okind_q <= ptom_pkg::KIND_FILLED;
              end else if (own_full) begin
                okind_q <= ptom_pkg::KIND_REJECT;
              end else begin
                okind_q <= ptom_pkg::KIND_RESTED;
              end
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Book summary fields track the chains as they stand after the update.
  logic signed [PRICE_BITS:0] best_bid, best_ask;
  logic [RC-1:0]              rcount;
  assign best_bid = bh_v ? {1'b0, bh_p} : '1;
  assign best_ask = ah_v ? {1'b0, ah_p} : '1;
  assign rcount = RC'(b_cnt) + RC'(a_cnt);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tlast = olast_q;
  assign m_axis_tuser = okind_q;
  assign m_axis_tdata = OW'({rcount, best_ask, best_bid, orleft_q, oleft_q, oprice_q,
                             otraded_q, ores_id_q, oinc_id_q});
endmodule
`default_nettype wire
